/* rtl/core/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg: shared types and codes of the indexed list store
// Command and status codes, and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package isl_pkg;

	localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [2:0] CMD_POP_BACK   = 3'd1;
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd2;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
	localparam logic [2:0] CMD_INSERT     = 3'd4;
	localparam logic [2:0] CMD_ERASE      = 3'd5;
	localparam logic [2:0] CMD_READ       = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// ins: open a slot at the position (cells above take their lower neighbor)
	// del: close the slot at the position (cells at and above take their upper neighbor)
	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctrl_t;

endpackage

/* rtl/core/isl_cell.sv */
// ----------------------------------------------------------------------------
// isl_cell: one entry of the list
// Holds one word and picks own, lower neighbor, upper neighbor or new word.
// ----------------------------------------------------------------------------
module isl_cell #(
	parameter int IDX   = 0,
	parameter int IW    = 4,
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  isl_pkg::cell_ctrl_t ctrl,
	input  logic [IW-1:0]       pos,
	input  logic [WIDTH-1:0]    new_word,
	input  logic [WIDTH-1:0]    lower_word,
	input  logic [WIDTH-1:0]    upper_word,
	output logic [WIDTH-1:0]    word
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [WIDTH-1:0] word_q;
	logic [WIDTH-1:0] word_d;

	always_comb begin
		word_d = word_q;
		if (ctrl.ins) begin
			if (MY_IDX == pos) begin
				word_d = new_word;
			end else if (MY_IDX > pos) begin
				word_d = lower_word;
			end
		end else if (ctrl.del && (MY_IDX >= pos)) begin
			word_d = upper_word;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

/* rtl/core/indexed_list_store_unit.sv */
// ----------------------------------------------------------------------------
// indexed_list_store_unit: ordered list of up to DEPTH words with a count
// Push/pop at either end, insert/erase/read at a position, one result each.
// ----------------------------------------------------------------------------
// Result: registered; it appears on m_tvalid in the cycle after its request is taken.
// Throughput: one request per cycle while results are taken; every cell picks
// its next word in the same cycle, and the output register frees s_tready.
// Reset: clears the count and the output valid; entry words are not cleared
// and no clearing pass runs, so requests are taken from the first cycle.
module indexed_list_store_unit #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] command, [7:3] position, [39:8] value
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] read_value, [36:32] entry_count, [38:37] status, [39] zero
	output logic [39:0] m_tdata
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int CMPW = (CW > 5) ? CW : 5;

	// request fields
	logic [2:0]  command;
	logic [4:0]  position;
	logic [31:0] value;

	assign command  = s_tdata[2:0];
	assign position = s_tdata[7:3];
	assign value    = s_tdata[39:8];

	logic s_accept;
	logic m_tvalid_q;

	// take a request whenever the output register is empty or being drained
	assign s_tready = !m_tvalid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	// list state
	logic [CW-1:0]    count_q;
	logic [WIDTH-1:0] words [DEPTH];

	logic            full;
	logic            empty;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign pos_x = CMPW'(position);
	assign cnt_x = CMPW'(count_q);

	// decode one request into cell control, next count and result
	isl_pkg::cell_ctrl_t ctrl_d;
	isl_pkg::cell_ctrl_t ctrl;
	logic [IW-1:0]       cell_pos;
	logic [CW-1:0]       count_d;
	logic [1:0]          status_d;
	logic [WIDTH-1:0]    rd_d;
	logic [WIDTH-1:0]    new_word;

	assign new_word = WIDTH'(value);

	always_comb begin
		ctrl_d   = '0;
		cell_pos = IW'(position);
		count_d  = count_q;
		status_d = isl_pkg::ST_OK;
		rd_d     = '0;
		case (command)
			isl_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_d = isl_pkg::ST_FULL;
				end else begin
					// open the slot just past the last entry
					ctrl_d.ins = 1'b1;
					cell_pos   = count_q[IW-1:0];
					count_d    = count_q + 1'b1;
				end
			end
			isl_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_d = isl_pkg::ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			isl_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = isl_pkg::ST_FULL;
				end else begin
					ctrl_d.ins = 1'b1;
					cell_pos   = '0;
					count_d    = count_q + 1'b1;
				end
			end
			isl_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_d = isl_pkg::ST_EMPTY;
				end else begin
					ctrl_d.del = 1'b1;
					cell_pos   = '0;
					count_d    = count_q - 1'b1;
				end
			end
			isl_pkg::CMD_INSERT: begin
				// full takes priority over a bad position
				if (full) begin
					status_d = isl_pkg::ST_FULL;
				end else if (pos_x > cnt_x) begin
					status_d = isl_pkg::ST_RANGE;
				end else begin
					ctrl_d.ins = 1'b1;
					count_d    = count_q + 1'b1;
				end
			end
			isl_pkg::CMD_ERASE: begin
				if (pos_x >= cnt_x) begin
					status_d = isl_pkg::ST_RANGE;
				end else begin
					ctrl_d.del = 1'b1;
					count_d    = count_q - 1'b1;
				end
			end
			isl_pkg::CMD_READ: begin
				if (pos_x >= cnt_x) begin
					status_d = isl_pkg::ST_RANGE;
				end else begin
					rd_d = words[IW'(position)];
				end
			end
			default: begin
				// unused code: hold everything, report ok
			end
		endcase
	end

	// cells move only on a taken request
	assign ctrl.ins = ctrl_d.ins && s_accept;
	assign ctrl.del = ctrl_d.del && s_accept;

	// row of cells, each wired to its two neighbors; the ends loop to themselves
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		logic [WIDTH-1:0] lower_w;
		logic [WIDTH-1:0] upper_w;

		if (gi == 0) begin : g_lo_end
			assign lower_w = words[gi];
		end else begin : g_lo
			assign lower_w = words[gi-1];
		end

		if (gi == DEPTH - 1) begin : g_hi_end
			assign upper_w = words[gi];
		end else begin : g_hi
			assign upper_w = words[gi+1];
		end

		isl_cell #(
			.IDX   (gi),
			.IW    (IW),
			.WIDTH (WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.pos        (cell_pos),
			.new_word   (new_word),
			.lower_word (lower_w),
			.upper_word (upper_w),
			.word       (words[gi])
		);
	end

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s_accept) begin
			count_q <= count_d;
		end
	end

	// result register
	logic [WIDTH-1:0] rd_q;
	logic [4:0]       cnt_out_q;
	logic [1:0]       status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			rd_q      <= rd_d;
			cnt_out_q <= 5'(count_d);
			status_q  <= status_d;
		end
	end

	logic [63:0] rd_ext;

	// widen or cut the stored word to the 32-bit result field
	assign rd_ext   = 64'(rd_q);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, status_q, cnt_out_q, rd_ext[31:0]};

	// count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count above capacity");

	// count moves only with a taken request
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_accept |=> $stable(count_q))
		else $error("count changed without a request");

	// pop back on an empty list reports empty and leaves the list empty
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && empty && (command == isl_pkg::CMD_POP_BACK) |=>
			m_tvalid && (status_q == isl_pkg::ST_EMPTY) && (count_q == '0))
		else $error("pop on empty list not flagged");

	// a read outside the list returns zero
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (command == isl_pkg::CMD_READ) && (pos_x >= cnt_x) |=>
			(rd_q == '0) && (status_q == isl_pkg::ST_RANGE))
		else $error("out-of-range read not zero");

endmodule

/* bench/indexed_list_store_unit_tb.sv */
// ----------------------------------------------------------------------------
// indexed_list_store_unit_tb: self-checking bench of the indexed list store
// Streams push, pop, insert, erase and read requests through the block with
// random gaps on both sides, mirrors the list in a shadow copy and checks
// every response word, count and status against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam int LIST_DEPTH = 16;

// Expected response, fields as they sit in m_tdata.
typedef struct packed {
	logic [31:0] read_value;
	logic [4:0]  entry_count;
	logic [1:0]  status;
} list_result_t;

// Shadow copy of the list; predicts the response of every accepted request.
class list_shadow;
	logic [31:0]  words [LIST_DEPTH];
	int unsigned  held;
	list_result_t awaited [$];
	int unsigned  errors;
	int unsigned  requests;
	int unsigned  responses;
	int unsigned  status_seen [4];

	function new();
		held      = 0;
		errors    = 0;
		requests  = 0;
		responses = 0;
		foreach (status_seen[k])
			status_seen[k] = 0;
	endfunction

	function int unsigned outstanding();
		return awaited.size();
	endfunction

	// Shift entries at and above the slot up by one and drop the word in.
	function void open_slot(int unsigned at, logic [31:0] word);
		int unsigned i;
		for (i = held; i > at; i--)
			words[i] = words[i - 1];
		words[at] = word;
		held++;
	endfunction

	// Shift entries above the slot down by one over it.
	function void close_slot(int unsigned at);
		int unsigned i;
		for (i = at; i + 1 < held; i++)
			words[i] = words[i + 1];
		held--;
	endfunction

	function void take_request(logic [39:0] req);
		logic [2:0]   op;
		logic [4:0]   at;
		logic [31:0]  word;
		list_result_t res;
		op   = req[2:0];
		at   = req[7:3];
		word = req[39:8];
		res.read_value = '0;
		res.status     = isl_pkg::ST_OK;
		case (op)
			isl_pkg::CMD_PUSH_BACK: begin
				if (held >= LIST_DEPTH)
					res.status = isl_pkg::ST_FULL;
				else
					open_slot(held, word);
			end
			isl_pkg::CMD_POP_BACK: begin
				if (held == 0)
					res.status = isl_pkg::ST_EMPTY;
				else
					held--;
			end
			isl_pkg::CMD_PUSH_FRONT: begin
				if (held >= LIST_DEPTH)
					res.status = isl_pkg::ST_FULL;
				else
					open_slot(0, word);
			end
			isl_pkg::CMD_POP_FRONT: begin
				if (held == 0)
					res.status = isl_pkg::ST_EMPTY;
				else
					close_slot(0);
			end
			isl_pkg::CMD_INSERT: begin
				// full wins over a bad position
				if (held >= LIST_DEPTH)
					res.status = isl_pkg::ST_FULL;
				else if (at > held)
					res.status = isl_pkg::ST_RANGE;
				else
					open_slot(at, word);
			end
			isl_pkg::CMD_ERASE: begin
				if (at >= held)
					res.status = isl_pkg::ST_RANGE;
				else
					close_slot(at);
			end
			isl_pkg::CMD_READ: begin
				if (at >= held)
					res.status = isl_pkg::ST_RANGE;
				else
					res.read_value = words[at];
			end
			default: ;
		endcase
		res.entry_count = held[4:0];
		awaited = {awaited, res};
		status_seen[res.status]++;
		requests++;
	endfunction

	function void check_response(logic [39:0] rsp);
		list_result_t want;
		responses++;
		if (awaited.size() == 0) begin
			$display("%0t: response %h arrived with none expected", $time, rsp);
			errors++;
			return;
		end
		want = awaited[0];
		awaited.delete(0);
		if (rsp[31:0] !== want.read_value) begin
			$display("%0t: read_value expected %h actual %h", $time, want.read_value,
				rsp[31:0]);
			errors++;
		end
		if (rsp[36:32] !== want.entry_count) begin
			$display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
				rsp[36:32]);
			errors++;
		end
		if (rsp[38:37] !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, rsp[38:37]);
			errors++;
		end
		if (rsp[39] !== 1'b0) begin
			$display("%0t: pad bit expected 0 actual %b", $time, rsp[39]);
			errors++;
		end
	endfunction
endclass

module indexed_list_store_unit_tb;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 7;
	localparam int RANDOM_REQUESTS = 1700;
	localparam int HOLD_AFTER      = 600;   // responses seen before the long receiver hold
	localparam int HOLD_CYCLES     = 400;
	localparam int STALL_LIMIT     = 4000;  // quiet cycles before the run is called hung
	localparam int DRAIN_CYCLES    = 10;

	// Not a command; the block must answer it and leave the list alone.
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [2:0] command, [7:3] position, [39:8] value
	logic [39:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [31:0] read_value, [36:32] entry_count, [38:37] status, [39] zero
	logic [39:0] m_tdata;

	list_shadow shadow = new();

	int fill_level   = 0;   // sender's own view of the count, for shaping positions
	bit sender_calm  = 1'b0;
	bit draining     = 1'b0;

	indexed_list_store_unit #(
		.DEPTH(LIST_DEPTH),
		.WIDTH(32)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Mostly no gap, some short, a few long.
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Count after a request, used only to aim positions at the live range.
	function automatic int fill_after(logic [2:0] op, logic [4:0] at, int fill);
		case (op)
			isl_pkg::CMD_PUSH_BACK, isl_pkg::CMD_PUSH_FRONT:
				return (fill < LIST_DEPTH) ? fill + 1 : fill;
			isl_pkg::CMD_INSERT:
				return (fill < LIST_DEPTH && at <= fill) ? fill + 1 : fill;
			isl_pkg::CMD_POP_BACK, isl_pkg::CMD_POP_FRONT:
				return (fill > 0) ? fill - 1 : fill;
			isl_pkg::CMD_ERASE:
				return (at < fill) ? fill - 1 : fill;
			default: return fill;
		endcase
	endfunction

	// Offer one request after an optional gap and hold it until it is taken.
	task automatic send_request(input logic [2:0] op, input logic [4:0] at,
			input logic [31:0] word);
		int gap;
		gap = sender_calm ? 0 : idle_span();
		if (gap > 0) begin
			// drop valid and scramble the bus so stale data never counts
			s_tvalid <= 1'b0;
			s_tdata  <= {$urandom, 8'($urandom)};
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {word, at, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		fill_level = fill_after(op, at, fill_level);
	endtask

	// Random request: drift toward full, then toward empty, with some noise.
	task automatic random_request();
		int          r;
		int          pick;
		logic [2:0]  op;
		logic [4:0]  at;
		logic [31:0] word;
		if (fill_level == 0)
			draining = 1'b0;
		else if (fill_level == LIST_DEPTH && $urandom_range(0, 3) == 0)
			draining = 1'b1;
		r    = $urandom_range(0, 99);
		pick = $urandom_range(0, 2);
		if (r < (draining ? 15 : 50))
			op = (pick == 0) ? isl_pkg::CMD_PUSH_BACK :
				(pick == 1) ? isl_pkg::CMD_PUSH_FRONT : isl_pkg::CMD_INSERT;
		else if (r < 65)
			op = (pick == 0) ? isl_pkg::CMD_POP_BACK :
				(pick == 1) ? isl_pkg::CMD_POP_FRONT : isl_pkg::CMD_ERASE;
		else if (r < 97)
			op = isl_pkg::CMD_READ;
		else
			op = CMD_UNUSED;
		// position: usually inside the live range, sometimes anywhere
		if ($urandom_range(0, 9) == 0)
			at = 5'($urandom_range(0, 31));
		else if (op == isl_pkg::CMD_INSERT)
			at = 5'($urandom_range(0, fill_level));
		else if (op == isl_pkg::CMD_ERASE || op == isl_pkg::CMD_READ)
			at = (fill_level > 0) ? 5'($urandom_range(0, fill_level - 1)) : 5'd0;
		else
			at = 5'($urandom_range(0, 31));
		case ($urandom_range(0, 15))
			0:       word = 32'h0000_0000;
			1:       word = 32'hFFFF_FFFF;
			default: word = $urandom;
		endcase
		send_request(op, at, word);
	endtask

	// Record requests before responses so a same-edge pair stays in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				shadow.take_request(s_tdata);
			if (m_tvalid && m_tready)
				shadow.check_response(m_tdata);
		end
	end

	// Receiver: random stalls, plus one long hold that backs the block up.
	initial begin : sink
		int span;
		bit held_off;
		held_off = 1'b0;
		forever begin
			if (!held_off && shadow.responses >= HOLD_AFTER) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				span = idle_span();
				if (span > 0) begin
					m_tready <= 1'b0;
					repeat (span) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// Call the run hung when no request or response moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles, %0d responses outstanding", $time,
			STALL_LIMIT, shadow.outstanding());
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int i;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: every removal and every read is refused
		send_request(isl_pkg::CMD_POP_BACK, 5'd0, 32'h0);
		send_request(isl_pkg::CMD_POP_FRONT, 5'd0, 32'h0);
		send_request(isl_pkg::CMD_ERASE, 5'd0, 32'h0);
		send_request(isl_pkg::CMD_READ, 5'd0, 32'h0);
		send_request(isl_pkg::CMD_INSERT, 5'd1, 32'h1234_5678);   // one past the end

		// fill to capacity: ends, append by insert at the count, and the middle
		for (i = 0; i < LIST_DEPTH; i++) begin
			case (i % 4)
				0: send_request(isl_pkg::CMD_PUSH_BACK, 5'd0, 32'hFFFF_FFFF);
				1: send_request(isl_pkg::CMD_PUSH_FRONT, 5'd31, 32'h0000_0000);
				2: send_request(isl_pkg::CMD_INSERT, 5'(i), 32'hAAAA_AAAA);
				default: send_request(isl_pkg::CMD_INSERT, 5'd1, 32'h5555_5555);
			endcase
		end

		// full list: full is reported before the bad position on insert
		send_request(isl_pkg::CMD_PUSH_BACK, 5'd0, 32'hDEAD_0001);
		send_request(isl_pkg::CMD_INSERT, 5'd31, 32'hDEAD_0002);
		send_request(isl_pkg::CMD_READ, 5'd15, 32'h0);
		send_request(isl_pkg::CMD_READ, 5'd16, 32'h0);

		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 100 == 0)
				sender_calm = ($urandom_range(0, 3) == 0);
			if (i == RANDOM_REQUESTS / 2) begin
				// pause the sender until the block has answered everything
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (shadow.outstanding() != 0)
					@(posedge clk);
			end
			random_request();
		end
		s_tvalid <= 1'b0;

		while (shadow.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d responses to %0d requests, %0d field errors.",
			shadow.responses, shadow.requests, shadow.errors);
		$display("Status mix: ok %0d, full %0d, empty %0d, out of range %0d.",
			shadow.status_seen[isl_pkg::ST_OK], shadow.status_seen[isl_pkg::ST_FULL],
			shadow.status_seen[isl_pkg::ST_EMPTY], shadow.status_seen[isl_pkg::ST_RANGE]);
		if (shadow.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
